// ===== sv/lwb_pkg.sv =====
// ----------------------------------------------------------------------------
// lwb_pkg: shared types and constants for the Lax-Wendroff Burgers stencil
// Sample format, Courant register format, request and result payloads and the
// control word that travels with each request through the flux pipeline.
// ----------------------------------------------------------------------------
package lwb_pkg;

	localparam int SAMPLE_BITS  = 16;
	localparam int FRAC_BITS    = SAMPLE_BITS - 2;
	localparam int COURANT_BITS = 16;

	localparam logic [COURANT_BITS-1:0] COURANT_RESET = COURANT_BITS'(3277);

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [COURANT_BITS-1:0] courant_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          row_end;
	} in_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] new_sample;
		logic                          last;
	} out_t;

	// what one request turns into at the output
	typedef struct packed {
		logic res;    // request gives a first result
		logic zero;   // first result is a boundary zero
		logic last1;  // first result closes the row
		logic extra;  // a trailing boundary zero with last follows
	} ctl_t;

endpackage

// ===== sv/lwb_cell.sv =====
// ----------------------------------------------------------------------------
// lwb_cell: one window cell
// Holds one grid sample and hands it to the next cell of the window chain
// whenever a request is taken.
// ----------------------------------------------------------------------------
module lwb_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  lwb_pkg::sample_t d,
	output lwb_pkg::sample_t q
);

	lwb_pkg::sample_t sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= '0;
		end else if (en) begin
			sample_q <= d;
		end
	end

	assign q = sample_q;

endmodule

// ===== sv/lwb_flux.sv =====
// ----------------------------------------------------------------------------
// lwb_flux: three-stage flux pipeline
// Squares, cubic flux products and first-order term, second-order term, then
// the sum with saturation on the way out. All stages move together on en.
// ----------------------------------------------------------------------------
module lwb_flux (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              valid,
	input  lwb_pkg::ctl_t     ctl,
	input  lwb_pkg::sample_t  l,
	input  lwb_pkg::sample_t  c,
	input  lwb_pkg::sample_t  r,
	input  lwb_pkg::courant_t courant,
	output logic              valid_out,
	output lwb_pkg::ctl_t     ctl_out,
	output lwb_pkg::sample_t  value
);

	localparam int N     = lwb_pkg::SAMPLE_BITS;
	localparam int F     = lwb_pkg::FRAC_BITS;
	localparam int CB    = lwb_pkg::COURANT_BITS;
	localparam int SQ_W  = N + 2;
	localparam int SUM_W = N + 1;
	localparam int PR_W  = N + 4;
	localparam int Q_W   = N + 5;
	localparam int T1_W  = N + 1;
	localparam int T2_W  = N + 2;
	localparam int V_W   = N + 3;
	localparam int B2_W  = 2 * CB;
	localparam int PW    = B2_W + 1 + Q_W;
	localparam int T1_SHIFT = 18;
	localparam int T2_SHIFT = 35;

	// divide by 2^s, round to nearest, ties away from zero
	function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] p, input int s);
		logic signed [PW-1:0] half;
		logic signed [PW-1:0] x;
		half = PW'(1) <<< (s - 1);
		x = p + half;
		if (p[PW-1]) begin
			x = x - PW'(1);
		end
		return x >>> s;
	endfunction

	logic [B2_W-1:0] b2_q;
	logic signed [CB:0] b_ext;
	logic signed [B2_W:0] b2_ext;

	always_ff @(posedge clk) begin
		b2_q <= B2_W'(courant) * B2_W'(courant);
	end

	assign b_ext  = {1'b0, courant};
	assign b2_ext = {1'b0, b2_q};

	// stage 1: squares and neighbor sums
	logic signed [PW-1:0] ll_p, cc_p, rr_p;
	logic signed [SQ_W-1:0] l2_s1, c2_s1, r2_s1;
	logic signed [SUM_W-1:0] rc_s1, cl_s1;
	lwb_pkg::sample_t c_s1;
	logic v_s1;
	lwb_pkg::ctl_t ctl_s1;

	always_comb begin
		ll_p = PW'(l) * PW'(l);
		cc_p = PW'(c) * PW'(c);
		rr_p = PW'(r) * PW'(r);
	end

	// stage 2: cubic flux differences and first-order term
	logic signed [SQ_W-1:0] d_rc, d_cl, d_rl;
	logic signed [PW-1:0] p1_p, p2_p, t1_p;
	logic signed [PR_W-1:0] p1_s2, p2_s2;
	logic signed [T1_W-1:0] t1_s2;
	lwb_pkg::sample_t c_s2;
	logic v_s2;
	lwb_pkg::ctl_t ctl_s2;

	always_comb begin
		d_rc = r2_s1 - c2_s1;
		d_cl = c2_s1 - l2_s1;
		d_rl = r2_s1 - l2_s1;
		p1_p = PW'(rc_s1) * PW'(d_rc);
		p2_p = PW'(cl_s1) * PW'(d_cl);
		t1_p = PW'(b_ext) * PW'(d_rl);
	end

	// stage 3: second-order term
	logic signed [Q_W-1:0] q;
	logic signed [PW-1:0] t2_p;
	logic signed [T2_W-1:0] t2_s3;
	logic signed [T1_W-1:0] t1_s3;
	lwb_pkg::sample_t c_s3;
	logic v_s3;
	lwb_pkg::ctl_t ctl_s3;

	always_comb begin
		q    = Q_W'(p1_s2) - Q_W'(p2_s2);
		t2_p = PW'(b2_ext) * PW'(q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (en) begin
			v_s1   <= valid;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			ctl_s1 <= ctl;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			l2_s1 <= SQ_W'(rnd(ll_p, F));
			c2_s1 <= SQ_W'(rnd(cc_p, F));
			r2_s1 <= SQ_W'(rnd(rr_p, F));
			rc_s1 <= SUM_W'(r) + SUM_W'(c);
			cl_s1 <= SUM_W'(c) + SUM_W'(l);
			c_s1  <= c;
			p1_s2 <= PR_W'(rnd(p1_p, F));
			p2_s2 <= PR_W'(rnd(p2_p, F));
			t1_s2 <= T1_W'(rnd(t1_p, T1_SHIFT));
			c_s2  <= c_s1;
			t2_s3 <= T2_W'(rnd(t2_p, T2_SHIFT));
			t1_s3 <= t1_s2;
			c_s3  <= c_s2;
		end
	end

	// sum and clamp to the sample range
	logic signed [V_W-1:0] v;

	always_comb begin
		v = V_W'(c_s3) - V_W'(t1_s3) + V_W'(t2_s3);
		if (!v[V_W-1] && (|v[V_W-2:N-1])) begin
			value = {1'b0, {(N-1){1'b1}}};
		end else if (v[V_W-1] && !(&v[V_W-2:N-1])) begin
			value = {1'b1, {(N-1){1'b0}}};
		end else begin
			value = v[N-1:0];
		end
	end

	assign valid_out = v_s3;
	assign ctl_out   = ctl_s3;

endmodule

// ===== sv/burgers_lax_wendroff_stencil_top.sv =====
// ----------------------------------------------------------------------------
// burgers_lax_wendroff_stencil_top: one Burgers time step over a streamed row
// Two window cells hold left and centre samples, a three-stage flux pipeline
// forms the Lax-Wendroff update, and an output register holds each result.
// ----------------------------------------------------------------------------
//
//  channel | handshake             | payload
//  --------+-----------------------+----------------------------
//  in      | in_valid / in_ready   | in_data  (sample, row_end)
//  out     | out_valid / out_ready | out_data (new_sample, last)
//  cfg     | cfg_we                | cfg_data (courant, Q0.16)
//
//  one request is taken per cycle while in_ready is high; s1-s3 then out_q
//  a row-end request gives two results unless it is its row's only sample;
//  in_ready stays low while its first result waits ahead of the trailing zero
//  a stall on out_ready freezes the window cells and the whole flux pipeline
//  reset clears the window and row position and sets courant to 3277
//
module burgers_lax_wendroff_stencil_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  lwb_pkg::in_t              in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output lwb_pkg::out_t             out_data,
	input  logic                      cfg_we,
	input  logic [lwb_pkg::COURANT_BITS-1:0] cfg_data
);

	typedef enum logic [1:0] {
		ROW_START,
		ROW_ONE,
		ROW_MID
	} seen_t;

	seen_t seen_q;
	lwb_pkg::courant_t courant_q;
	logic out_valid_q;
	logic extra_q;
	lwb_pkg::out_t out_q;

	logic adv;
	logic fire;
	lwb_pkg::ctl_t ctl;
	lwb_pkg::sample_t centre;
	lwb_pkg::sample_t left;
	logic f_valid;
	lwb_pkg::ctl_t f_ctl;
	lwb_pkg::sample_t f_value;

	// output slot frees when empty or taken with nothing trailing
	assign adv      = !out_valid_q || (out_ready && !extra_q);
	assign in_ready = adv;
	assign fire     = in_valid && adv;

	always_comb begin
		ctl = '0;
		unique case (seen_q)
			ROW_START: begin
				ctl.res   = in_data.row_end;
				ctl.zero  = 1'b1;
				ctl.last1 = 1'b1;
			end
			ROW_ONE: begin
				ctl.res   = 1'b1;
				ctl.zero  = 1'b1;
				ctl.extra = in_data.row_end;
			end
			ROW_MID: begin
				ctl.res   = 1'b1;
				ctl.extra = in_data.row_end;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= ROW_START;
		end else if (fire) begin
			if (in_data.row_end) begin
				seen_q <= ROW_START;
			end else if (seen_q == ROW_START) begin
				seen_q <= ROW_ONE;
			end else begin
				seen_q <= ROW_MID;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			courant_q <= lwb_pkg::COURANT_RESET;
		end else if (cfg_we) begin
			courant_q <= cfg_data;
		end
	end

	lwb_cell u_centre (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (fire),
		.d      (in_data.sample),
		.q      (centre)
	);

	lwb_cell u_left (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (fire),
		.d      (centre),
		.q      (left)
	);

	lwb_flux u_flux (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.valid     (fire),
		.ctl       (ctl),
		.l         (left),
		.c         (centre),
		.r         (in_data.sample),
		.courant   (courant_q),
		.valid_out (f_valid),
		.ctl_out   (f_ctl),
		.value     (f_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			extra_q     <= 1'b0;
		end else if (adv) begin
			out_valid_q <= f_valid && f_ctl.res;
			extra_q     <= f_valid && f_ctl.res && f_ctl.extra;
		end else if (out_ready && extra_q) begin
			extra_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.new_sample <= f_ctl.zero ? '0 : f_value;
			out_q.last       <= f_ctl.last1;
		end else if (out_ready && extra_q) begin
			// trailing boundary zero of the row
			out_q.new_sample <= '0;
			out_q.last       <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_extra_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		extra_q |-> out_valid_q)
		else $error("trailing result pending without a held result");

	a_first_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && extra_q) |-> !out_q.last)
		else $error("result ahead of the trailing zero marked last");

	a_trailing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && extra_q) |=>
			(out_valid && out_data.last && (out_data.new_sample == '0)))
		else $error("trailing boundary zero did not follow");

endmodule
